[rtl/plst_pkg.sv]
// Package for the positional list store: sizes, operation and status codes,
// and the command struct that the control logic broadcasts to the slot cells.
// No dependencies.
package plst_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Width of the entry counter (holds 0..DEPTH) and of slot indexes.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Common width for comparing positions, counts and slot indexes.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_BITS  = OP_W + POS_W + VALUE_W;
	localparam int OUT_BITS = STATUS_W + VALUE_W + COUNT_W + 2;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_RETRIEVE = 3'd2,
		OP_REPLACE  = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	// Command seen by every slot cell in the same cycle.
	typedef struct packed {
		logic                  ins;
		logic                  rem;
		logic                  rep;
		logic [CMP_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] word;
	} cell_cmd_t;

endpackage

[rtl/plst_cell.sv]
// One slot of the positional list store: holds one word, loads a new word on insert or replace
// at its own index, and takes the word of a neighbor on insert or remove shifts. Depends on plst_pkg.
module plst_cell
	import plst_pkg::*;
(
	input  logic                  clk,
	input  logic [CMP_W-1:0]      idx,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] below,
	input  logic [DATA_WIDTH-1:0] above,
	output logic [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx == cmd.pos) begin
				word_q <= cmd.word;
			end else if (idx > cmd.pos) begin
				word_q <= below;
			end
		end else if (cmd.rem) begin
			if (idx >= cmd.pos) begin
				word_q <= above;
			end
		end else if (cmd.rep && (idx == cmd.pos)) begin
			word_q <= cmd.word;
		end
	end

	assign word = word_q;

endmodule

[rtl/positional_list_store_top.sv]
// Positional list store: an ordered list of up to DEPTH words in a row of slot cells.
// Each accepted input transfer has its result loaded into the output register,
// and one request is taken every cycle while the result side keeps up; all cells
// shift together at the edge that takes the request.
// Reset (arst_n, asynchronous, active low) empties the list and drops the output
// valid; slot words are not cleared and are only read below the entry count.
module positional_list_store_top
	import plst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata, from bit 0: op[2:0], position[7:3], value[39:8]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata, from bit 0: status[1:0], read_value[33:2], entry_count[38:34],
	// is_full[39], is_empty[40], zero fill above
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// Input fields unpacked from the transfer.
	logic [OP_W-1:0]    op;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	assign op       = s_tdata[OP_W-1:0];
	assign position = s_tdata[OP_W+POS_W-1:OP_W];
	assign value    = s_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W];

	// The entry count and the output register.
	logic [CNT_W-1:0]    used_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic                is_full_q;
	logic                is_empty_q;

	// A new request is taken whenever the output register is free or is being
	// emptied in this same cycle, so the result side never stalls the input
	// for longer than it stalls itself.
	logic s_accept;
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// Slot words from every cell, used for the neighbor shifts and the read.
	logic [DATA_WIDTH-1:0] cell_word [DEPTH];

	// Request decode. The positions and the count are compared at a common
	// width so that the design holds for any DEPTH.
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      used_ext;
	logic [DATA_WIDTH-1:0] sel_word;
	status_t               status_nxt;
	logic [CNT_W-1:0]      used_nxt;
	logic [VALUE_W-1:0]    rd_nxt;
	cell_cmd_t             cmd;
	cell_cmd_t             cmd_go;
	logic [CMP_W-1:0]      used_nxt_ext;

	assign pos_ext  = CMP_W'(position);
	assign used_ext = CMP_W'(used_q);
	// Only read where the position lies below the count, so a slot index past
	// the row never reaches the result.
	assign sel_word = cell_word[IDX_W'(pos_ext)];

	always_comb begin
		status_nxt = ST_OK;
		used_nxt   = used_q;
		rd_nxt     = '0;
		cmd.ins    = 1'b0;
		cmd.rem    = 1'b0;
		cmd.rep    = 1'b0;
		cmd.pos    = pos_ext;
		cmd.word   = DATA_WIDTH'(value);
		unique case (op)
			OP_INSERT: begin
				if (used_q == CNT_W'(DEPTH)) begin
					status_nxt = ST_OVER;
				end else if (pos_ext > used_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					cmd.ins  = 1'b1;
					used_nxt = CNT_W'(used_q + 1'b1);
				end
			end
			OP_REMOVE: begin
				if (used_q == '0) begin
					status_nxt = ST_UNDER;
				end else if (pos_ext >= used_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					cmd.rem  = 1'b1;
					rd_nxt   = VALUE_W'(sel_word);
					used_nxt = CNT_W'(used_q - 1'b1);
				end
			end
			OP_RETRIEVE: begin
				if (pos_ext >= used_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					rd_nxt = VALUE_W'(sel_word);
				end
			end
			OP_REPLACE: begin
				if (pos_ext >= used_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					cmd.rep = 1'b1;
				end
			end
			OP_CLEAR: begin
				// The slot words stay; only the count drops.
				used_nxt = '0;
			end
			default: begin
				// Unused op codes report out of range and leave the list alone.
				status_nxt = ST_RANGE;
			end
		endcase
	end

	// The cells move only on an accepted request.
	always_comb begin
		cmd_go     = cmd;
		cmd_go.ins = cmd.ins && s_accept;
		cmd_go.rem = cmd.rem && s_accept;
		cmd_go.rep = cmd.rep && s_accept;
	end

	// The row of slot cells. Cell 0 never shifts up and the last cell keeps
	// its own word on a remove.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_inner_below
			assign below = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign above = cell_word[i];
		end else begin : g_inner_above
			assign above = cell_word[i+1];
		end

		plst_cell u_cell (
			.clk   (clk),
			.idx   (CMP_W'(i)),
			.cmd   (cmd_go),
			.below (below),
			.above (above),
			.word  (cell_word[i])
		);
	end

	assign used_nxt_ext = CMP_W'(used_nxt);

	// Control state: count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				used_q     <= used_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded with each accepted request.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			status_q      <= status_nxt;
			read_value_q  <= rd_nxt;
			entry_count_q <= used_nxt_ext[COUNT_W-1:0];
			is_full_q     <= (used_nxt == CNT_W'(DEPTH));
			is_empty_q    <= (used_nxt == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({is_empty_q, is_full_q, entry_count_q,
		read_value_q, status_q});

endmodule

[tb/positional_list_store_top_tb.sv]
// Testbench for positional_list_store_top: sends list requests as stream transfers,
// predicts every result with its own copy of the list, and checks each result transfer.
// Depends on plst_pkg and the RTL top module.
`timescale 1ns / 1ps

module positional_list_store_top_tb;
	import plst_pkg::*;

	// Op codes that the block does not define. They still yield one result.
	localparam logic [OP_W-1:0] OP_UNDEF_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_UNDEF_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI  = 3'd7;

	// Traffic shapes for the random part: the list mostly grows, mostly shrinks,
	// or is edited in place with inserts and removes in balance.
	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_CHURN  = 2;

	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_ITEMS  = 150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// One result, laid out as m_tdata carries it (status in the lowest bits).
	typedef struct packed {
		logic               is_empty;
		logic               is_full;
		logic [COUNT_W-1:0] entry_count;
		logic [VALUE_W-1:0] read_value;
		status_t            status;
	} list_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	positional_list_store_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Shadow copy of the list: the words in order and how many are held.
	logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
	int                    shadow_len;

	// Results predicted for accepted requests, oldest first.
	list_result_t pending_results [$];

	int           fail_count;
	int           cycle_count;
	bit           send_idle_on;
	bit           recv_idle_on;
	int           recv_stall_left;
	list_result_t seen_result;
	list_result_t want_result;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Works out the result of one request and applies it to the shadow list.
	// Inserts shift later words up, removes shift them down; a failed request
	// leaves the list untouched and reads back zero.
	function automatic list_result_t apply_list_request(logic [OP_W-1:0] op_code,
			logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value);
		list_result_t r;
		int           i;
		r.status     = ST_OK;
		r.read_value = '0;
		case (op_code)
			OP_INSERT: begin
				if (shadow_len >= DEPTH) begin
					r.status = ST_OVER;
				end else if (pos > shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = value[DATA_WIDTH-1:0];
					shadow_len++;
				end
			end
			OP_REMOVE: begin
				if (shadow_len == 0) begin
					r.status = ST_UNDER;
				end else if (pos >= shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = VALUE_W'(shadow_words[pos]);
					shadow_len--;
					for (i = pos; i < shadow_len; i++)
						shadow_words[i] = shadow_words[i+1];
				end
			end
			OP_RETRIEVE: begin
				if (pos >= shadow_len)
					r.status = ST_RANGE;
				else
					r.read_value = VALUE_W'(shadow_words[pos]);
			end
			OP_REPLACE: begin
				if (pos >= shadow_len)
					r.status = ST_RANGE;
				else
					shadow_words[pos] = value[DATA_WIDTH-1:0];
			end
			OP_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.entry_count = COUNT_W'(shadow_len);
		r.is_full     = (shadow_len == DEPTH);
		r.is_empty    = (shadow_len == 0);
		return r;
	endfunction

	// Sends one request and returns at the edge where it is accepted. The valid
	// line stays high between back-to-back requests; it only drops for an idle burst.
	task automatic send_list_request(logic [OP_W-1:0] op_code, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] value);
		if (send_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({value, pos, op_code});
		do
			@(posedge clk);
		while (!s_tready);
		// The transfer happened at this edge, so the expectation goes in now.
		pending_results.push_back(apply_list_request(op_code, pos, value));
	endtask

	// Requests on an empty list: every access fails, and an insert past the end
	// is out of range.
	task automatic test_empty_requests();
		send_list_request(OP_REMOVE, 5'd0, 32'h0);
		send_list_request(OP_RETRIEVE, 5'd0, 32'h0);
		send_list_request(OP_REPLACE, 5'd0, 32'h1234_5678);
		send_list_request(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
	endtask

	// Inserts at the front, in the middle and at the end, then reads, overwrites
	// and removes, with the value field at both extremes.
	task automatic test_positional_edits();
		send_list_request(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
		send_list_request(OP_INSERT, 5'd0, 32'h0000_0000);
		send_list_request(OP_INSERT, 5'd2, 32'hA5A5_5A5A);
		send_list_request(OP_INSERT, 5'd1, 32'h8000_0001);
		send_list_request(OP_RETRIEVE, 5'd1, 32'h0);
		send_list_request(OP_REPLACE, 5'd0, 32'h7FFF_FFFE);
		send_list_request(OP_RETRIEVE, 5'd0, 32'h0);
		send_list_request(OP_REMOVE, 5'd1, 32'h0);
		send_list_request(OP_REMOVE, 5'd31, 32'h0);
		send_list_request(OP_INSERT, 5'd31, 32'h1111_1111);
		send_list_request(OP_REPLACE, 5'd16, 32'h2222_2222);
	endtask

	// The three undefined op codes are answered as out of range and change nothing.
	task automatic test_unknown_ops();
		send_list_request(OP_UNDEF_LO, 5'd0, 32'hDEAD_BEEF);
		send_list_request(OP_UNDEF_MID, 5'd31, 32'hFFFF_FFFF);
		send_list_request(OP_UNDEF_HI, 5'd1, 32'h0);
	endtask

	// Fills the list to DEPTH, tries one insert too many, works at the top slot,
	// and clears. The retrieve after the clear must be out of range even though
	// the slots still hold their words.
	task automatic test_full_list();
		while (shadow_len < DEPTH)
			send_list_request(OP_INSERT, POS_W'($urandom_range(0, shadow_len)), $urandom());
		send_list_request(OP_INSERT, 5'd0, 32'hCAFE_F00D);
		send_list_request(OP_RETRIEVE, POS_W'(DEPTH - 1), 32'h0);
		send_list_request(OP_REMOVE, POS_W'(DEPTH - 1), 32'h0);
		send_list_request(OP_INSERT, POS_W'(DEPTH - 1), 32'h0F0F_F0F0);
		send_list_request(OP_CLEAR, 5'd31, 32'hFFFF_FFFF);
		send_list_request(OP_RETRIEVE, 5'd0, 32'h0);
	endtask

	// Random traffic in chunks. Each chunk picks a shape (grow, shrink or churn)
	// so the count sweeps between empty and full many times, and decides whether
	// either side idles. Positions are mostly valid for the current count, with
	// some anywhere in the field. The last stretch runs with no idling at all.
	task automatic test_random_traffic();
		int               n;
		int               mode;
		int               ins_pct;
		int               rem_pct;
		int               roll;
		logic [OP_W-1:0]  op_code;
		logic [POS_W-1:0] pos;
		logic [VALUE_W-1:0] value;
		mode    = MODE_GROW;
		ins_pct = 60;
		rem_pct = 10;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				mode = $urandom_range(MODE_GROW, MODE_CHURN);
				case (mode)
					MODE_GROW: begin
						ins_pct = 60;
						rem_pct = 10;
					end
					MODE_SHRINK: begin
						ins_pct = 15;
						rem_pct = 55;
					end
					default: begin
						ins_pct = 35;
						rem_pct = 35;
					end
				endcase
				send_idle_on = ($urandom_range(0, 2) != 0);
				recv_idle_on = ($urandom_range(0, 2) != 0);
			end
			if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end

			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				op_code = OP_INSERT;
			else if (roll < ins_pct + rem_pct)
				op_code = OP_REMOVE;
			else if (roll < (ins_pct + rem_pct + 97) / 2)
				op_code = OP_RETRIEVE;
			else if (roll < 97)
				op_code = OP_REPLACE;
			else if (roll == 97)
				op_code = OP_CLEAR;
			else begin
				case ($urandom_range(0, 2))
					0: op_code = OP_UNDEF_LO;
					1: op_code = OP_UNDEF_MID;
					default: op_code = OP_UNDEF_HI;
				endcase
			end

			if ($urandom_range(0, 9) == 0)
				pos = POS_W'($urandom_range(0, 31));
			else if (op_code == OP_INSERT || shadow_len == 0)
				pos = POS_W'($urandom_range(0, shadow_len));
			else
				pos = POS_W'($urandom_range(0, shadow_len - 1));

			case ($urandom_range(0, 15))
				0: value = '0;
				1: value = '1;
				default: value = $urandom();
			endcase

			send_list_request(op_code, pos, value);
		end
	endtask

	// Result side: m_tready drops in stall bursts while receiver idling is allowed.
	always @(posedge clk) begin
		if (recv_stall_left > 0) begin
			recv_stall_left--;
			m_tready <= 1'b0;
		end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
			recv_stall_left = $urandom_range(1, 7) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result = list_result_t'(m_tdata[OUT_BITS-1:0]);
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result transfer: m_tdata=%h", m_tdata);
			end else begin
				want_result = pending_results.pop_front();
				if (seen_result.status !== want_result.status ||
						seen_result.read_value !== want_result.read_value ||
						seen_result.entry_count !== want_result.entry_count ||
						seen_result.is_full !== want_result.is_full ||
						seen_result.is_empty !== want_result.is_empty) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display({"result mismatch: expected status=%0d read=%h count=%0d ",
							"full=%b empty=%b, got status=%0d read=%h count=%0d ",
							"full=%b empty=%b"},
							want_result.status, want_result.read_value,
							want_result.entry_count, want_result.is_full,
							want_result.is_empty, seen_result.status,
							seen_result.read_value, seen_result.entry_count,
							seen_result.is_full, seen_result.is_empty);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		m_tready        = 1'b0;
		shadow_len      = 0;
		fail_count      = 0;
		cycle_count     = 0;
		recv_stall_left = 0;
		send_idle_on    = 1'b1;
		recv_idle_on    = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_requests();
		test_positional_edits();
		test_unknown_ops();
		test_full_list();
		test_random_traffic();

		// All requests are in; let the last results drain, then keep clocking so
		// that any stray result transfer still shows.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[positional_list_store_top.f]
rtl/plst_pkg.sv
rtl/plst_cell.sv
rtl/positional_list_store_top.sv
tb/positional_list_store_top_tb.sv
